[rtl/assert_macros.svh]
// assertion helpers, clocked on i_clk and quiet while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LDF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ldf_pkg.sv]
package ldf_pkg;

    typedef logic [1:0]  t_command;
    typedef logic [7:0]  t_byte;
    typedef logic [1:0]  t_kind;
    typedef logic [2:0]  t_error;
    typedef logic [16:0] t_count;
    typedef logic [15:0] t_length;

    localparam t_command CMD_DATA   = 2'd0;
    localparam t_command CMD_FINISH = 2'd1;
    localparam t_command CMD_CLEAR  = 2'd2;

    localparam t_kind KIND_NONE    = 2'd0;
    localparam t_kind KIND_PAYLOAD = 2'd1;
    localparam t_kind KIND_EOS     = 2'd2;
    localparam t_kind KIND_ERROR   = 2'd3;

    localparam t_error ERR_NONE     = 3'd0;
    localparam t_error ERR_ZERO     = 3'd1;
    localparam t_error ERR_OVER     = 3'd2;
    localparam t_error ERR_TRUNC    = 3'd3;
    localparam t_error ERR_FINISHED = 3'd4;

    localparam t_count HEADER_BYTES = 17'd2;

    localparam t_length MAX_PAYLOAD_RESET = 16'hFFFF;

    // register index taken from the byte address
    localparam logic REG_MAX_PAYLOAD = 1'b0;

endpackage

[rtl/ldf_in_if.sv]
interface ldf_in_if;
    logic               valid;
    logic               ready;
    ldf_pkg::t_command  command;
    ldf_pkg::t_byte     in_byte;

    modport source (output valid, output command, output in_byte, input ready);
    modport sink   (input valid, input command, input in_byte, output ready);
endinterface

[rtl/ldf_out_if.sv]
interface ldf_out_if;
    logic             valid;
    logic             ready;
    ldf_pkg::t_kind   kind;
    ldf_pkg::t_byte   payload_byte;
    logic             frame_end;
    ldf_pkg::t_error  error_code;
    ldf_pkg::t_count  frame_fill;
    logic             needs_more;

    modport source (
        output valid, output kind, output payload_byte, output frame_end,
        output error_code, output frame_fill, output needs_more, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input frame_end,
        input error_code, input frame_fill, input needs_more, output ready
    );
endinterface

[rtl/length_prefix_deframer_unit.sv]
// Splits a byte stream into frames of a 2-byte little-endian length header
// followed by that many payload bytes. Every input transaction (data byte,
// finish or clear) yields exactly one result transaction, registered in the cycle after it is taken:
// payload bytes pass straight through with frame_end on the last one, while
// valid header bytes, clear and the unused command give a "no data" result. A zero
// length or a length above min(max_payload, LENGTH_LIMIT) locks the decoder
// into a sticky error that only a clear removes; finish with a partial frame
// gives a sticky truncation error, and data after a clean finish gives a
// non-sticky "stream finished" error. One transaction is taken every cycle:
// the decode state (byte counter, length compare) is updated in the same
// cycle a transaction is taken, and a single result register decouples the
// output, so the input only stalls while that register is held by the sink.
// max_payload sits at APB byte address 0 and resets to 65535; write it only
// while no transaction is in flight.
`include "assert_macros.svh"

module length_prefix_deframer_unit #(
    parameter int LENGTH_LIMIT = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ldf_in_if.sink             i_in,
    ldf_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam ldf_pkg::t_length LP_LIMIT = ldf_pkg::t_length'(LENGTH_LIMIT);

    ldf_pkg::t_length r_max;
    ldf_pkg::t_count  r_count, n_count;
    ldf_pkg::t_byte   r_low, n_low;
    ldf_pkg::t_length r_expected, n_expected;
    ldf_pkg::t_error  r_sticky, n_sticky;
    logic             r_done, n_done;

    logic             r_out_valid;
    ldf_pkg::t_kind   r_kind, n_kind;
    ldf_pkg::t_byte   r_byte, n_byte;
    logic             r_end, n_end;
    ldf_pkg::t_error  r_err, n_err;
    ldf_pkg::t_count  r_buf, n_buf;
    logic             r_more, n_more;

    logic             in_fire;
    logic             out_stall;
    logic             cfg_write;
    ldf_pkg::t_length limit;
    ldf_pkg::t_length hdr_len;
    ldf_pkg::t_count  count_inc;
    ldf_pkg::t_count  frame_total;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == ldf_pkg::REG_MAX_PAYLOAD) ? {16'd0, r_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= ldf_pkg::MAX_PAYLOAD_RESET;
        end else if (cfg_write && paddr[2] == ldf_pkg::REG_MAX_PAYLOAD) begin
            r_max <= pwdata[15:0];
        end
    end

    // handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_stall  = r_out_valid && !o_out.ready;

    assign limit       = (r_max < LP_LIMIT) ? r_max : LP_LIMIT;
    assign hdr_len     = {i_in.in_byte, r_low};
    assign count_inc   = r_count + 17'd1;
    assign frame_total = ldf_pkg::t_count'(r_expected) + ldf_pkg::HEADER_BYTES;

    // decode
    always_comb begin
        n_count    = r_count;
        n_low      = r_low;
        n_expected = r_expected;
        n_sticky   = r_sticky;
        n_done     = r_done;
        n_kind     = ldf_pkg::KIND_NONE;
        n_byte     = 8'd0;
        n_end      = 1'b0;
        n_err      = ldf_pkg::ERR_NONE;
        n_buf      = r_count;
        n_more     = 1'b0;
        case (i_in.command)
            ldf_pkg::CMD_CLEAR: begin
                n_count    = 17'd0;
                n_low      = 8'd0;
                n_expected = 16'd0;
                n_sticky   = ldf_pkg::ERR_NONE;
                n_done     = 1'b0;
                n_buf      = 17'd0;
            end
            ldf_pkg::CMD_FINISH: begin
                if (r_sticky != ldf_pkg::ERR_NONE) begin
                    n_kind = ldf_pkg::KIND_ERROR;
                    n_err  = r_sticky;
                end else begin
                    n_done = 1'b1;
                    if (r_count != 17'd0) begin
                        n_sticky = ldf_pkg::ERR_TRUNC;
                        n_kind   = ldf_pkg::KIND_ERROR;
                        n_err    = ldf_pkg::ERR_TRUNC;
                    end else begin
                        n_kind = ldf_pkg::KIND_EOS;
                        n_buf  = 17'd0;
                    end
                end
            end
            ldf_pkg::CMD_DATA: begin
                if (r_sticky != ldf_pkg::ERR_NONE) begin
                    n_kind = ldf_pkg::KIND_ERROR;
                    n_err  = r_sticky;
                end else if (r_done) begin
                    n_kind = ldf_pkg::KIND_ERROR;
                    n_err  = ldf_pkg::ERR_FINISHED;
                end else if (r_count == 17'd0) begin
                    n_low   = i_in.in_byte;
                    n_count = 17'd1;
                    n_buf   = 17'd1;
                    n_more  = 1'b1;
                end else if (r_count == 17'd1) begin
                    n_count    = ldf_pkg::HEADER_BYTES;
                    n_expected = hdr_len;
                    n_buf      = ldf_pkg::HEADER_BYTES;
                    if (hdr_len == 16'd0) begin
                        n_sticky = ldf_pkg::ERR_ZERO;
                        n_kind   = ldf_pkg::KIND_ERROR;
                        n_err    = ldf_pkg::ERR_ZERO;
                    end else if (hdr_len > limit) begin
                        n_sticky = ldf_pkg::ERR_OVER;
                        n_kind   = ldf_pkg::KIND_ERROR;
                        n_err    = ldf_pkg::ERR_OVER;
                    end else begin
                        n_more = 1'b1;
                    end
                end else begin
                    n_kind = ldf_pkg::KIND_PAYLOAD;
                    n_byte = i_in.in_byte;
                    if (count_inc >= frame_total) begin
                        n_count    = 17'd0;
                        n_expected = 16'd0;
                        n_end      = 1'b1;
                        n_buf      = 17'd0;
                    end else begin
                        n_count = count_inc;
                        n_buf   = count_inc;
                        n_more  = 1'b1;
                    end
                end
            end
            default: begin
                n_more = (r_count != 17'd0);
            end
        endcase
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= 17'd0;
            r_low      <= 8'd0;
            r_expected <= 16'd0;
            r_sticky   <= ldf_pkg::ERR_NONE;
            r_done     <= 1'b0;
        end else if (in_fire) begin
            r_count    <= n_count;
            r_low      <= n_low;
            r_expected <= n_expected;
            r_sticky   <= n_sticky;
            r_done     <= n_done;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_end  <= n_end;
            r_err  <= n_err;
            r_buf  <= n_buf;
            r_more <= n_more;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_kind;
    assign o_out.payload_byte   = r_byte;
    assign o_out.frame_end      = r_end;
    assign o_out.error_code     = r_err;
    assign o_out.frame_fill     = r_buf;
    assign o_out.needs_more     = r_more;

    `LDF_ASSERT_NOW(a_sticky_cnt, |r_sticky, |r_count, "sticky error with empty frame")
    `LDF_ASSERT_NOW(a_payload_len, r_count > ldf_pkg::HEADER_BYTES, |r_expected, "no length")
    `LDF_ASSERT_NOW(a_done_empty, r_done && !(|r_sticky), !(|r_count), "finished mid frame")
    `LDF_ASSERT_NEXT(a_stall_hold, out_stall, r_out_valid && $stable(r_buf), "result dropped")

endmodule
